// ===== src/nsf_pkg.sv =====
// ---------------------------------------------------------------------------
// nsf_pkg: shared definitions for the NMEA sentence framer
// Buffer depth, character codes, parser phases and the result item type.
// ---------------------------------------------------------------------------
package nsf_pkg;

  localparam int LINE_DEPTH = 128;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam int OUT_IDX_W  = 7;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // body bytes stop at depth-4, checksum bytes at depth-1
  localparam logic [IDX_W-1:0] BODY_LIMIT = IDX_W'(LINE_DEPTH - 4);
  localparam logic [IDX_W-1:0] CSUM_LIMIT = IDX_W'(LINE_DEPTH - 1);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_BODY = 4'b0010,
    PH_CSUM = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic                 store_valid;
    logic [OUT_IDX_W-1:0] store_index;
    logic [7:0]           store_char;
    logic                 line_done;
    logic [OUT_IDX_W-1:0] line_length;
    logic [7:0]           xor_sum;
    logic                 star_seen;
    logic                 frame_dropped;
  } result_t;

  // Fit a buffer index to the 7-bit result fields
  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] v);
    logic [IDX_W+OUT_IDX_W-1:0] wide;
    wide = {{OUT_IDX_W{1'b0}}, v};
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

// ===== src/nsf_if.sv =====
// ---------------------------------------------------------------------------
// nsf_if: channel interfaces for the NMEA sentence framer
// Received byte channel and result item channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface nsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsf_out_if;
  logic       valid;
  logic       ready;
  logic       store_valid;
  logic [6:0] store_index;
  logic [7:0] store_char;
  logic       line_done;
  logic [6:0] line_length;
  logic [7:0] xor_sum;
  logic       star_seen;
  logic       frame_dropped;

  modport source (
    output valid, output store_valid, output store_index, output store_char,
    output line_done, output line_length, output xor_sum, output star_seen,
    output frame_dropped, input ready
  );
  modport sink (
    input valid, input store_valid, input store_index, input store_char,
    input line_done, input line_length, input xor_sum, input star_seen,
    input frame_dropped, output ready
  );
endinterface

// ===== src/nmea_sentence_framer_core.sv =====
// ---------------------------------------------------------------------------
// nmea_sentence_framer_core: byte-serial NMEA sentence framer
// Path: an accepted byte is held in the input register, then the parser
//   update for it is loaded into the result register and presented; an
//   output stall holds the byte in the input register.
// Throughput: one byte per cycle, bounded only by the sink's ready.
// Reset: synchronous, active low; parser idle, index, XOR and star cleared,
//   both registers emptied.
// ---------------------------------------------------------------------------
module nmea_sentence_framer_core
  import nsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  nsf_in_if.sink     in_ch,
  nsf_out_if.source  out_ch
);

  // Two-register pipe: byte register -> parser -> result register.
  // The parser state advances only when its result is loaded, so a stall on
  // the output side freezes the sentence state as well.

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       can_load;
  logic       step;
  result_t    res;

  assign step = byte_valid && can_load;

  nsf_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (step),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // Phase, write index, running XOR of body characters and star flag live here.
  nsf_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (byte_data),
    .res     (res)
  );

  nsf_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_req (byte_valid),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  // ---- checks ----

  // a byte is either stored, ends a line, drops a frame, or nothing
  a_excl_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> $countones({out_ch.store_valid, out_ch.line_done,
                                 out_ch.frame_dropped}) <= 1)
    else $error("result item carries more than one event");

  // position 0 only ever holds the sentence start
  a_start_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.store_valid && out_ch.store_index == '0)
      |-> out_ch.store_char == CH_DOLLAR)
    else $error("buffer position 0 written with a non-start character");

  // a finished line holds at least the start character
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.line_done) |-> out_ch.line_length != '0)
    else $error("completed line reports zero length");

  // the pipe never throttles the input while the sink is taking items
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output side is ready");

endmodule

// ===== src/nsf_in_stage.sv =====
// ---------------------------------------------------------------------------
// nsf_in_stage: input register
// Holds one received byte until the parser takes it.
// ---------------------------------------------------------------------------
module nsf_in_stage
  import nsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  nsf_in_if.sink     in_ch,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;

  assign in_ch.ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.ready) begin
      valid_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      data_r <= in_ch.rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

// ===== src/nsf_parser.sv =====
// ---------------------------------------------------------------------------
// nsf_parser: sentence state and per-byte update
// Phase, write index, running XOR and star flag; forms one result per byte.
// ---------------------------------------------------------------------------
module nsf_parser
  import nsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  phase_t             phase_r,  phase_nxt;
  logic [IDX_W-1:0]   widx_r,   widx_nxt;
  logic [7:0]         xor_r,    xor_nxt;
  logic               star_r,   star_nxt;
  logic               eol;

  assign eol = (rx_byte == CH_CR) || (rx_byte == CH_LF);

  always_comb begin
    phase_nxt = phase_r;
    widx_nxt  = widx_r;
    xor_nxt   = xor_r;
    star_nxt  = star_r;
    res       = '0;

    unique case (phase_r)
      PH_IDLE, PH_DONE: begin
        // after a finished line the parser restarts from idle
        phase_nxt = PH_IDLE;
        widx_nxt  = '0;
        xor_nxt   = '0;
        star_nxt  = 1'b0;
        if (rx_byte == CH_DOLLAR) begin
          phase_nxt       = PH_BODY;
          widx_nxt        = IDX_W'(1);
          res.store_valid = 1'b1;
          res.store_index = '0;
          res.store_char  = rx_byte;
        end
      end
      PH_BODY: begin
        if (rx_byte == CH_STAR) begin
          star_nxt        = 1'b1;
          phase_nxt       = PH_CSUM;
          res.store_valid = 1'b1;
          res.store_index = to_out_idx(widx_r);
          res.store_char  = rx_byte;
          widx_nxt        = widx_r + IDX_W'(1);
        end else if (eol) begin
          phase_nxt       = PH_DONE;
          res.line_done   = 1'b1;
          res.line_length = to_out_idx(widx_r);
          res.xor_sum     = xor_r;
          res.star_seen   = star_r;
        end else if (widx_r < BODY_LIMIT) begin
          xor_nxt         = xor_r ^ rx_byte;
          res.store_valid = 1'b1;
          res.store_index = to_out_idx(widx_r);
          res.store_char  = rx_byte;
          widx_nxt        = widx_r + IDX_W'(1);
        end else begin
          // body overflow: frame discarded
          phase_nxt         = PH_IDLE;
          res.frame_dropped = 1'b1;
        end
      end
      PH_CSUM: begin
        if (eol) begin
          phase_nxt       = PH_DONE;
          res.line_done   = 1'b1;
          res.line_length = to_out_idx(widx_r);
          res.xor_sum     = xor_r;
          res.star_seen   = star_r;
        end else if (widx_r < CSUM_LIMIT) begin
          res.store_valid = 1'b1;
          res.store_index = to_out_idx(widx_r);
          res.store_char  = rx_byte;
          widx_nxt        = widx_r + IDX_W'(1);
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      widx_r  <= '0;
      xor_r   <= '0;
      star_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      widx_r  <= widx_nxt;
      xor_r   <= xor_nxt;
      star_r  <= star_nxt;
    end
  end

endmodule

// ===== src/nsf_out_stage.sv =====
// ---------------------------------------------------------------------------
// nsf_out_stage: result register
// Holds one result item until the sink takes it.
// ---------------------------------------------------------------------------
module nsf_out_stage
  import nsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load_req,
  input  result_t  res,
  output logic     can_load,
  nsf_out_if.source out_ch
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_req && can_load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.store_valid   = res_r.store_valid;
  assign out_ch.store_index   = res_r.store_index;
  assign out_ch.store_char    = res_r.store_char;
  assign out_ch.line_done     = res_r.line_done;
  assign out_ch.line_length   = res_r.line_length;
  assign out_ch.xor_sum       = res_r.xor_sum;
  assign out_ch.star_seen     = res_r.star_seen;
  assign out_ch.frame_dropped = res_r.frame_dropped;

endmodule
